// ----- hw/rtl/mst_pkg.sv -----
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the multi-slot soft timer: operation codes,
// sequencer states, status codes and the packing of the stream payloads.
// ----------------------------------------------------------------------------
package mst_pkg;

   // request payload fields
   localparam int OP_W       = 3;
   localparam int SLOT_W     = 3;
   localparam int SPAN_W     = 32;
   localparam int NOW_W      = 32;
   localparam int SLOT_LSB   = 0;
   localparam int SPAN_LSB   = SLOT_LSB + SLOT_W;
   localparam int NOW_LSB    = SPAN_LSB + SPAN_W;
   localparam int REQ_DATA_W = 72;

   // response payload fields
   localparam int FSLOT_W        = 3;
   localparam int REM_W          = 32;
   localparam int MASK_W         = 8;
   localparam int RSP_STATUS_BIT = 0;
   localparam int RSP_SLOT_LSB   = 1;
   localparam int RSP_REM_LSB    = RSP_SLOT_LSB + FSLOT_W;
   localparam int RSP_MASK_LSB   = RSP_REM_LSB + REM_W;
   localparam int RSP_MORE_BIT   = RSP_MASK_LSB + MASK_W;
   localparam int RSP_DATA_W     = 48;
   localparam int RSP_USER_W     = 1;

   // status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INIT        = 3'd0,
      OP_START_ONE   = 3'd1,
      OP_START_PER   = 3'd2,
      OP_STOP        = 3'd3,
      OP_POLL        = 3'd4,
      OP_NEXT_DUE    = 3'd5,
      OP_RESET_ALL   = 3'd6
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FIRE,
      ST_READ,
      ST_LOAD,
      ST_WAIT
   } state_type;

endpackage

// ----- hw/rtl/mst_alu.sv -----
// ----------------------------------------------------------------------------
// mst_alu
// Shared tick adder/subtractor. Also flags the wrap-safe due condition of a
// difference taken as expiry minus now.
// ----------------------------------------------------------------------------
module mst_alu #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             due
);

   // one adder, b inverted for subtraction
   always_comb begin
      result = a + (sub ? ~b : b) + WIDTH'(sub);
   end

   // expiry - now is zero or negative but not the most negative value: now - expiry has top bit clear
   always_comb begin
      due = (result == '0) || (result[WIDTH-1] && (result[WIDTH-2:0] != '0));
   end

endmodule

// ----- hw/rtl/mst_fire_buf.sv -----
// ----------------------------------------------------------------------------
// mst_fire_buf
// Small buffer of slots fired during one poll, replayed once the poll is
// complete so that every response carries the final running mask.
// ----------------------------------------------------------------------------
module mst_fire_buf #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/multi_slot_soft_timer_core.sv -----
// ----------------------------------------------------------------------------
// multi_slot_soft_timer_core
// Bank of timer slots with one-shot and periodic modes, polled for expiries
// and queried for the time to the next expiry.
//
//   channel  | direction | tvalid/tready | payload
//   ---------+-----------+---------------+-------------------------------------
//   req_     | in        | yes           | tuser op, tdata slot/span_ms/now
//   rsp_     | out       | yes           | tuser fired, tdata status..more, tlast
//
// init, start, stop, reset all: states exec, read, load, wait, plus response stall
// next due: one slot per cycle through the shared adder, then read, load, wait
// poll with F fires: a full scan before each fire update and one after the last,
//   then each response is replayed from the fire buffer through read, load, wait
// reset is synchronous and clears slot flags, the list count and handshakes
// one transaction at a time: req_tready is low until the last response is taken
// ----------------------------------------------------------------------------
module multi_slot_soft_timer_core #(
   parameter int NUM_TIMERS = 8,
   parameter int MAX_FIRES  = 16,
   parameter int TICK_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] slot, [34:3] span_ms, [66:35] now, [71:67] zero
   input  logic [mst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] op
   input  logic [mst_pkg::OP_W-1:0]          req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] status, [3:1] fired_slot, [35:4] remaining_ms, [43:36] running_mask,
   // [44] more_pending, [47:45] zero
   output logic [mst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] fired
   output logic [mst_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   import mst_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int RW = $clog2(NUM_TIMERS + 1);
   localparam int FW = $clog2(MAX_FIRES + 1);
   localparam int AW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
   localparam int TW = TICK_WIDTH;

   // sequencer
   state_type state_ff, state_in;

   // captured transaction
   op_type              op_ff, op_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [TW-1:0]       span_ff, span_in;
   logic [TW-1:0]       now_ff, now_in;
   logic                status_ff, status_in;

   // slot state
   logic [TW-1:0]         period_ff [NUM_TIMERS];
   logic [TW-1:0]         expiry_ff [NUM_TIMERS];
   logic [RW-1:0]         rank_ff   [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] periodic_ff;
   logic [NUM_TIMERS-1:0] running_ff;
   logic [NUM_TIMERS-1:0] listed_ff;
   logic [RW-1:0]         count_ff;

   // scan and poll bookkeeping
   logic [IW-1:0]  idx_ff, idx_in;
   logic           hit_found_ff, hit_found_in;
   logic [IW-1:0]  hit_ff, hit_in;
   logic [RW-1:0]  hit_rank_ff, hit_rank_in;
   logic [REM_W-1:0] best_ff, best_in;
   logic [FW-1:0]  fires_ff, fires_in;
   logic           more_ff, more_in;
   logic [FW-1:0]  emit_ff, emit_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic [FSLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [REM_W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic              rsp_more_ff, rsp_more_in;
   logic              rsp_last_ff, rsp_last_in;

   // datapath
   op_type         req_op;
   logic [IW-1:0]  sidx;
   logic           slot_ok;
   logic           exec_reject;
   logic [IW-1:0]  rd_idx;
   logic [TW-1:0]  expiry_rd;
   logic [TW-1:0]  alu_a, alu_b, alu_res;
   logic           alu_sub, alu_due;
   logic [REM_W-1:0] rem_ms;
   logic           poll_cand, next_cand, last_slot;
   logic           poll_fire;
   logic [MASK_W-1:0] run_mask;
   logic [IW-1:0]  buf_rd_data;

   assign req_op  = op_type'(req_tuser);
   assign sidx    = IW'(slot_ff);
   assign slot_ok = (32'(slot_ff) < 32'(NUM_TIMERS));

   // running mask, slots beyond the mask width never show
   genvar g;
   generate
      for (g = 0; g < MASK_W; g++) begin : g_mask
         if (g < NUM_TIMERS) begin : g_live
            assign run_mask[g] = running_ff[g];
         end else begin : g_none
            assign run_mask[g] = 1'b0;
         end
      end
   endgenerate

   // reject decisions of single-step operations
   always_comb begin
      unique case (op_ff)
         OP_INIT:                   exec_reject = !slot_ok || listed_ff[sidx];
         OP_START_ONE, OP_START_PER: exec_reject = !slot_ok || (span_ff == '0);
         OP_STOP:                   exec_reject = !slot_ok || !running_ff[sidx];
         OP_POLL, OP_NEXT_DUE,
         OP_RESET_ALL:              exec_reject = 1'b0;
         default:                   exec_reject = 1'b1;
      endcase
   end

   // shared adder operand select
   assign rd_idx    = (state_ff == ST_FIRE) ? hit_ff : idx_ff;
   assign expiry_rd = expiry_ff[rd_idx];

   always_comb begin
      unique case (state_ff)
         ST_EXEC: begin
            alu_a   = now_ff;
            alu_b   = span_ff;
            alu_sub = 1'b0;
         end
         ST_FIRE: begin
            alu_a   = expiry_rd;
            alu_b   = period_ff[hit_ff];
            alu_sub = 1'b0;
         end
         default: begin
            alu_a   = expiry_rd;
            alu_b   = now_ff;
            alu_sub = 1'b1;
         end
      endcase
   end

   mst_alu #(
      .WIDTH (TW)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .due    (alu_due)
   );

   // per-slot scan candidates
   always_comb begin
      rem_ms    = alu_due ? '0 : REM_W'(alu_res);
      poll_cand = listed_ff[idx_ff] && running_ff[idx_ff] && alu_due &&
                  (!hit_found_ff || (rank_ff[idx_ff] > hit_rank_ff));
      next_cand = running_ff[idx_ff] && (rem_ms < best_ff);
      last_slot = (idx_ff == IW'(NUM_TIMERS - 1));
      poll_fire = (op_ff == OP_POLL) && (fires_ff != '0);
   end

   // fired slots of the current poll
   mst_fire_buf #(
      .DEPTH  (MAX_FIRES),
      .ADDR_W (AW),
      .DATA_W (IW)
   ) u_fire_buf (
      .clock   (clock),
      .wr_en   (state_ff == ST_FIRE),
      .wr_addr (fires_ff[AW-1:0]),
      .wr_data (hit_ff),
      .rd_addr (emit_ff[AW-1:0]),
      .rd_data (buf_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((req_op == OP_POLL) || (req_op == OP_NEXT_DUE)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: state_in = ST_READ;
         ST_SCAN: begin
            if (last_slot) begin
               if ((op_ff == OP_POLL) && hit_found_in &&
                   (fires_ff != FW'(MAX_FIRES))) begin
                  state_in = ST_FIRE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_FIRE: state_in = ST_SCAN;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_WAIT;
         ST_WAIT: begin
            if (rsp_tready) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and response register next values
   always_comb begin
      op_in         = op_ff;
      slot_in       = slot_ff;
      span_in       = span_ff;
      now_in        = now_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      hit_found_in  = hit_found_ff;
      hit_in        = hit_ff;
      hit_rank_in   = hit_rank_ff;
      best_in       = best_ff;
      fires_in      = fires_ff;
      more_in       = more_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_more_in   = rsp_more_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_op;
               slot_in      = req_tdata[SLOT_LSB +: SLOT_W];
               span_in      = req_tdata[SPAN_LSB +: TW];
               now_in       = req_tdata[NOW_LSB +: TW];
               status_in    = STATUS_OK;
               idx_in       = '0;
               hit_found_in = 1'b0;
               best_in      = '1;
               fires_in     = '0;
               more_in      = 1'b0;
               emit_in      = '0;
            end
         end
         ST_EXEC: status_in = exec_reject ? STATUS_REJECT : STATUS_OK;
         ST_SCAN: begin
            if ((op_ff == OP_POLL) && poll_cand) begin
               hit_found_in = 1'b1;
               hit_in       = idx_ff;
               hit_rank_in  = rank_ff[idx_ff];
            end
            if ((op_ff == OP_NEXT_DUE) && next_cand) begin
               best_in = rem_ms;
            end
            if (last_slot) begin
               idx_in = '0;
               if ((op_ff == OP_POLL) && hit_found_in &&
                   (fires_ff == FW'(MAX_FIRES))) begin
                  more_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIRE: begin
            fires_in     = fires_ff + 1'b1;
            hit_found_in = 1'b0;
            idx_in       = '0;
         end
         ST_READ: begin
         end
         ST_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_fired_in  = poll_fire;
            rsp_slot_in   = poll_fire ? FSLOT_W'(buf_rd_data) : '0;
            rsp_rem_in    = (op_ff == OP_NEXT_DUE) ? best_ff : '0;
            rsp_mask_in   = run_mask;
            rsp_last_in   = !poll_fire || (emit_ff == (fires_ff - 1'b1));
            rsp_more_in   = rsp_last_in && more_ff;
         end
         ST_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (!rsp_last_ff) begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction and response payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      span_ff       <= span_in;
      now_ff        <= now_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      hit_found_ff  <= hit_found_in;
      hit_ff        <= hit_in;
      hit_rank_ff   <= hit_rank_in;
      best_ff       <= best_in;
      fires_ff      <= fires_in;
      more_ff       <= more_in;
      emit_ff       <= emit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_more_ff   <= rsp_more_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // slot flags and list count
   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= '0;
         running_ff  <= '0;
         listed_ff   <= '0;
         count_ff    <= '0;
      end else if ((state_ff == ST_EXEC) && !exec_reject) begin
         unique case (op_ff)
            OP_INIT: begin
               periodic_ff[sidx] <= 1'b0;
               running_ff[sidx]  <= 1'b0;
            end
            OP_START_ONE, OP_START_PER: begin
               if (!listed_ff[sidx]) begin
                  listed_ff[sidx] <= 1'b1;
                  count_ff        <= count_ff + 1'b1;
               end
               running_ff[sidx]  <= 1'b1;
               periodic_ff[sidx] <= (op_ff == OP_START_PER);
            end
            OP_STOP: running_ff[sidx] <= 1'b0;
            OP_RESET_ALL: begin
               listed_ff  <= '0;
               running_ff <= '0;
               count_ff   <= '0;
            end
            default: begin
            end
         endcase
      end else if ((state_ff == ST_FIRE) && !periodic_ff[hit_ff]) begin
         running_ff[hit_ff] <= 1'b0;
      end
   end

   // slot periods, expiries and list ranks
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EXEC) && !exec_reject) begin
         if (op_ff == OP_INIT) begin
            period_ff[sidx] <= '0;
            expiry_ff[sidx] <= '0;
         end else if ((op_ff == OP_START_ONE) || (op_ff == OP_START_PER)) begin
            period_ff[sidx] <= span_ff;
            expiry_ff[sidx] <= alu_res;
            if (!listed_ff[sidx]) begin
               rank_ff[sidx] <= count_ff;
            end
         end
      end else if ((state_ff == ST_FIRE) && periodic_ff[hit_ff]) begin
         expiry_ff[hit_ff] <= alu_res;
      end
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_fired_ff);
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[RSP_STATUS_BIT]              = rsp_status_ff;
      rsp_tdata[RSP_SLOT_LSB +: FSLOT_W]     = rsp_slot_ff;
      rsp_tdata[RSP_REM_LSB +: REM_W]        = rsp_rem_ff;
      rsp_tdata[RSP_MASK_LSB +: MASK_W]      = rsp_mask_ff;
      rsp_tdata[RSP_MORE_BIT]                = rsp_more_ff;
   end

endmodule

// ----- hw/rtl/mst_checker.sv -----
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks of the soft timer core, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mst_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);

   import mst_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("response changed while stalled");

   // no new request while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while response pending");

   // an accepted request keeps the block busy and gives no instant response
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !rsp_tvalid))
      else $error("block ready right after a request transaction");

   // expiry reports carry accepted status and no remaining time
   a_fire_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         ((rsp_tdata[RSP_STATUS_BIT] == STATUS_OK) &&
          (rsp_tdata[RSP_REM_LSB +: REM_W] == '0)))
      else $error("fired response with bad status or remaining time");

   // more pending only on the final expiry report
   a_more_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_MORE_BIT]) |-> (rsp_tlast && rsp_tuser[0]))
      else $error("more pending outside the final fired response");

endmodule

bind multi_slot_soft_timer_core mst_checker u_mst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- verif/multi_slot_soft_timer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_soft_timer_core_tb
// Self-checking bench for the timer bank. A short directed table covers
// rejects, the fire cap, wrap-around expiry and reset-all, then a long random
// run of start/poll/query sequences follows. Every response is compared with a
// software copy of the slot bank or with a hand-written answer, with random stalls
// on both stream channels.
module multi_slot_soft_timer_core_tb;
   import mst_pkg::*;

   localparam int NUM_SLOTS       = 8;
   localparam int FIRE_CAP        = 16;
   localparam int NUM_DIRECTED    = 26;
   localparam int RANDOM_ITEMS    = 450;
   localparam int STALL_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int LONG_HOLD_AFTER = 150;
   localparam int LONG_HOLD_LEN   = 400;

   // op code outside the defined set, answered with a reject
   localparam logic [OP_W-1:0] OP_ILLEGAL = 3'd7;
   localparam logic [31:0]     NO_TIMER   = 32'hFFFF_FFFF;

   // one response as the bank should produce it
   typedef struct packed {
      logic        status;
      logic        fired;
      logic [2:0]  fired_slot;
      logic [31:0] remaining;
      logic [7:0]  running;
      logic        more;
      logic        last;
   } timer_result_type;

   // one request, with an optional answer written out by hand
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [2:0]      slot;
      logic [31:0]     span;
      logic [31:0]     now;
      logic            has_answer;
      logic            t_status;
      logic [31:0]     t_remaining;
      logic [7:0]      t_running;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // shadow copy of the slot bank
   logic [31:0]          slot_period [NUM_SLOTS] = '{default: '0};
   logic [31:0]          slot_expiry [NUM_SLOTS] = '{default: '0};
   logic [3:0]           slot_rank   [NUM_SLOTS] = '{default: '0};
   logic [NUM_SLOTS-1:0] slot_periodic = '0;
   logic [NUM_SLOTS-1:0] slot_running  = '0;
   logic [NUM_SLOTS-1:0] slot_listed   = '0;
   logic [3:0]           list_count    = '0;

   timer_result_type step_results[$];
   timer_result_type pending_results[$];
   stim_row_type     directed_rows [NUM_DIRECTED];
   int               error_count     = 0;
   int               responses_taken = 0;

   multi_slot_soft_timer_core #(
      .NUM_TIMERS (NUM_SLOTS),
      .MAX_FIRES  (FIRE_CAP),
      .TICK_WIDTH (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // wrap-safe test: due once now has reached the expiry tick
   function automatic logic slot_due(input int s, input logic [31:0] now);
      logic [31:0] lag;
      lag = now - slot_expiry[s];
      return !lag[31];
   endfunction

   // most recently listed slot that is due, -1 if none
   function automatic int newest_due(input logic [31:0] now);
      int best;
      best = -1;
      for (int s = 0; s < NUM_SLOTS; s++)
         if (slot_listed[s] && slot_running[s] && slot_due(s, now))
            if (best < 0 || slot_rank[s] > slot_rank[best])
               best = s;
      return best;
   endfunction

   // apply one request to the shadow bank and collect its responses
   task automatic timer_bank_step(input logic [OP_W-1:0] op, input logic [2:0] slot,
                                  input logic [31:0] span, input logic [31:0] now);
      timer_result_type res;
      int          hit;
      int          fires;
      logic [31:0] gap_ms;
      step_results.delete();
      res = '0;
      case (op)
         OP_INIT: begin
            if (slot_listed[slot]) begin
               res.status = STATUS_REJECT;
            end else begin
               slot_period[slot]   = '0;
               slot_expiry[slot]   = '0;
               slot_periodic[slot] = 1'b0;
               slot_running[slot]  = 1'b0;
            end
         end
         OP_START_ONE, OP_START_PER: begin
            if (span == '0) begin
               res.status = STATUS_REJECT;
            end else begin
               if (!slot_listed[slot]) begin
                  slot_listed[slot] = 1'b1;
                  slot_rank[slot]   = list_count;
                  list_count++;
               end
               slot_period[slot]   = span;
               slot_expiry[slot]   = now + span;
               slot_running[slot]  = 1'b1;
               slot_periodic[slot] = (op == OP_START_PER);
            end
         end
         OP_STOP: begin
            if (!slot_running[slot])
               res.status = STATUS_REJECT;
            else
               slot_running[slot] = 1'b0;
         end
         OP_POLL: begin
            // periodic slots catch up and may fire again in the same poll
            fires = 0;
            hit   = newest_due(now);
            while (fires < FIRE_CAP && hit >= 0) begin
               if (slot_periodic[hit])
                  slot_expiry[hit] = slot_expiry[hit] + slot_period[hit];
               else
                  slot_running[hit] = 1'b0;
               res.fired      = 1'b1;
               res.fired_slot = hit[2:0];
               step_results.push_back(res);
               fires++;
               hit = newest_due(now);
            end
            if (fires == FIRE_CAP && hit >= 0)
               step_results[step_results.size()-1].more = 1'b1;
         end
         OP_NEXT_DUE: begin
            res.remaining = NO_TIMER;
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (slot_running[s]) begin
                  gap_ms = slot_due(s, now) ? 32'd0 : slot_expiry[s] - now;
                  if (gap_ms < res.remaining)
                     res.remaining = gap_ms;
               end
            end
         end
         OP_RESET_ALL: begin
            slot_listed  = '0;
            slot_running = '0;
            list_count   = '0;
         end
         default: res.status = STATUS_REJECT;
      endcase
      if (step_results.size() == 0)
         step_results.push_back(res);
      foreach (step_results[k]) begin
         step_results[k].running = slot_running;
         step_results[k].last    = (k == step_results.size() - 1);
      end
   endtask

   // idle stretch: mostly short, now and then long
   function automatic int idle_stretch();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // offer one request and record what it should produce once taken
   task automatic offer_request(input stim_row_type row, input bit calm);
      int                    gap;
      logic [REQ_DATA_W-1:0] data;
      timer_result_type      answer;
      gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_stretch();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      data = '0;
      data[SLOT_LSB +: SLOT_W] = row.slot;
      data[SPAN_LSB +: SPAN_W] = row.span;
      data[NOW_LSB +: NOW_W]   = row.now;
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      timer_bank_step(row.op, row.slot, row.span, row.now);
      if (row.has_answer) begin
         answer           = '0;
         answer.status    = row.t_status;
         answer.remaining = row.t_remaining;
         answer.running   = row.t_running;
         answer.last      = 1'b1;
         pending_results.push_back(answer);
      end else begin
         foreach (step_results[k])
            pending_results.push_back(step_results[k]);
      end
   endtask

   // hold the request channel until every response is back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin : rsp_monitor
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_taken++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected transaction, tdata 0x%0h tuser %0b tlast %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_tdata[RSP_STATUS_BIT]));
            compare_field("fired", 32'(want.fired), 32'(rsp_tuser[0]));
            compare_field("fired_slot", 32'(want.fired_slot),
                          32'(rsp_tdata[RSP_SLOT_LSB +: FSLOT_W]));
            compare_field("remaining_ms", want.remaining, rsp_tdata[RSP_REM_LSB +: REM_W]);
            compare_field("running_mask", 32'(want.running),
                          32'(rsp_tdata[RSP_MASK_LSB +: MASK_W]));
            compare_field("more_pending", 32'(want.more), 32'(rsp_tdata[RSP_MORE_BIT]));
            compare_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // response side back-pressure, with one long hold-off
   initial begin : rsp_pacing
      int stall_left;
      bit calm;
      bit long_hold_done;
      stall_left     = 0;
      calm           = 1'b0;
      long_hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 149) == 0)
            calm = !calm;
         if (!long_hold_done && responses_taken >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_LEN;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30) begin
            stall_left = idle_stretch();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // no transaction on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** multi_slot_soft_timer_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      logic [31:0]  tick;
      int           pick;
      bit           calm;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_INIT;
      calm = 1'b0;
      tick = 32'd100;
      // op, slot, span, now, hand-written answer, status, remaining, running mask
      directed_rows = '{
         '{OP_NEXT_DUE,  3'd0, 32'd0,        32'd0,        1'b1, STATUS_OK,     NO_TIMER, 8'h00},
         '{OP_ILLEGAL,   3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, STATUS_REJECT, 32'd0,    8'h00},
         '{OP_START_ONE, 3'd3, 32'd0,        32'd5,        1'b1, STATUS_REJECT, 32'd0,    8'h00},
         '{OP_STOP,      3'd0, 32'd0,        32'd0,        1'b1, STATUS_REJECT, 32'd0,    8'h00},
         '{OP_POLL,      3'd0, 32'd0,        32'd0,        1'b1, STATUS_OK,     32'd0,    8'h00},
         '{OP_INIT,      3'd0, 32'd0,        32'd0,        1'b1, STATUS_OK,     32'd0,    8'h00},
         '{OP_START_ONE, 3'd0, 32'd10,       32'd0,        1'b1, STATUS_OK,     32'd0,    8'h01},
         '{OP_INIT,      3'd0, 32'd0,        32'd0,        1'b1, STATUS_REJECT, 32'd0,    8'h01},
         '{OP_START_PER, 3'd7, 32'd1,        32'd0,        1'b1, STATUS_OK,     32'd0,    8'h81},
         '{OP_NEXT_DUE,  3'd0, 32'd0,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         // fast periodic slot runs into the fire cap, then catches up
         '{OP_POLL,      3'd0, 32'd0,        32'd20,       1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_POLL,      3'd0, 32'd0,        32'd20,       1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_STOP,      3'd7, 32'd0,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         // largest span and expiries across the tick wrap
         '{OP_START_PER, 3'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_START_ONE, 3'd5, 32'h20,       32'hFFFFFFF0, 1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_NEXT_DUE,  3'd0, 32'd0,        32'hFFFFFFF8, 1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_POLL,      3'd0, 32'd0,        32'h5,        1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_POLL,      3'd0, 32'd0,        32'h10,       1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_RESET_ALL, 3'd0, 32'd0,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_NEXT_DUE,  3'd0, 32'd0,        32'd0,        1'b1, STATUS_OK,     NO_TIMER, 8'h00},
         '{OP_INIT,      3'd2, 32'd0,        32'd0,        1'b1, STATUS_OK,     32'd0,    8'h00},
         // half-range distance is not yet due
         '{OP_START_ONE, 3'd1, 32'h80000000, 32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_NEXT_DUE,  3'd0, 32'd0,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         // one-shot restart drops the periodic mark
         '{OP_START_PER, 3'd4, 32'd3,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_START_ONE, 3'd4, 32'd3,        32'd0,        1'b0, STATUS_OK,     32'd0,    8'h00},
         '{OP_POLL,      3'd0, 32'd0,        32'd3,        1'b0, STATUS_OK,     32'd0,    8'h00}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i], calm);
      wait_for_drain();

      // random start/poll traffic on a slowly advancing tick
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            wait_for_drain();
         if ($urandom_range(0, 39) == 0)
            calm = !calm;
         row  = '0;
         pick = $urandom_range(0, 99);
         if (pick < 22)
            row.op = OP_START_ONE;
         else if (pick < 42)
            row.op = OP_START_PER;
         else if (pick < 52)
            row.op = OP_STOP;
         else if (pick < 60)
            row.op = OP_INIT;
         else if (pick < 82)
            row.op = OP_POLL;
         else if (pick < 94)
            row.op = OP_NEXT_DUE;
         else if (pick < 97)
            row.op = OP_RESET_ALL;
         else
            row.op = OP_ILLEGAL;
         row.slot = 3'($urandom_range(0, NUM_SLOTS - 1));
         pick = $urandom_range(0, 99);
         if (pick < 5)
            row.span = '0;
         else if (pick < 15)
            row.span = $urandom;
         else if (pick < 18)
            row.span = NO_TIMER - $urandom_range(0, 3);
         else
            row.span = $urandom_range(1, 40);
         if ($urandom_range(0, 99) < 6)
            tick = $urandom;
         else
            tick = tick + $urandom_range(0, 12);
         row.now = tick;
         offer_request(row, calm);
      end
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("** multi_slot_soft_timer_core: PASSED **");
      else
         $display("** multi_slot_soft_timer_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mst_pkg.sv
hw/rtl/mst_alu.sv
hw/rtl/mst_fire_buf.sv
hw/rtl/multi_slot_soft_timer_core.sv
hw/rtl/mst_checker.sv
verif/multi_slot_soft_timer_core_tb.sv
